// ===== hw/rtl/mofe_pkg.sv =====
package mofe_pkg;

  // item kinds on the input channel
  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_FILL    = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_REFRESH = 2'd3;

  // panel command bytes of the page refresh header
  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // header slots ahead of the data bytes of a page
  localparam int unsigned HEADER_SLOTS = 3;

  localparam int unsigned BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== hw/rtl/mofe_ram.sv =====
module mofe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mono_oled_framebuffer_engine.sv =====
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+----------------------------------------------
// input     | in        | in_valid / in_ready  | kind, x_first, y_first, x_last, y_last,
//           |           |                      | pixel_value
// output    | out       | out_valid / out_ready| out_byte, is_data, frame_end
//
// a point reads its byte of the frame ram, then writes it back; a refresh tick reads the
// frame ram for a data byte, then loads the output register; a fill reads and writes back each
// byte it touches (columns times pages spanned) in turn, through the single read-modify-write
// path of the frame ram; reset and a clear transaction start a clearing pass over the whole
// ram, DEPTH words (1024 at the default size), one word a cycle, with in_ready low throughout
// a refresh byte waits in place while the output register is full; input resumes as it moves
module mono_oled_framebuffer_engine #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] x_first,
  input  logic [7:0] y_first,
  input  logic [7:0] x_last,
  input  logic [7:0] y_last,
  input  logic       pixel_value,

  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       frame_end
);

  localparam int unsigned ROWS   = 8 * PAGES;
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned ADDR_W = COL_W + PAGE_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned SLOTS  = COLUMNS + mofe_pkg::HEADER_SLOTS;
  localparam int unsigned OFF_W  = $clog2(SLOTS);

  localparam logic [8:0]        COL_MAX   = 9'(COLUMNS - 1);
  localparam logic [8:0]        ROW_MAX   = 9'(ROWS - 1);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);
  localparam logic [OFF_W-1:0]  OFF_LAST  = OFF_W'(SLOTS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_REF_OUT
  } state_t;

  state_t state;

  // clearing pass
  logic [ADDR_W-1:0] clr_addr;

  // refresh walk
  logic [PAGE_W-1:0] refresh_page;
  logic [OFF_W-1:0]  refresh_offset;

  // rectangle walk: columns outer, row blocks inner
  logic [COL_W-1:0]  fill_column;
  logic [COL_W-1:0]  col_last;
  logic [PAGE_W-1:0] fill_block;
  logic [PAGE_W-1:0] blk_first;
  logic [PAGE_W-1:0] blk_last;
  logic [2:0]        bit_first;
  logic [2:0]        bit_last;
  logic              pix_val;

  // refresh byte on its way to the output register
  mofe_pkg::byte_t   pend_cmd;
  logic              pend_data;
  logic              pend_end;

  // frame ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  mofe_pkg::byte_t   ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  mofe_pkg::byte_t   ram_rdata;

  // decode of the incoming transaction
  logic              accept;
  logic [7:0]        x_end_in;
  logic [7:0]        y_end_in;
  logic [8:0]        x_end_clip;
  logic [8:0]        y_end_clip;
  logic              draw_empty;
  logic              draw_go;
  logic [PAGE_W-1:0] blk_in_first;
  logic [PAGE_W-1:0] blk_in_last;
  logic              ref_is_data;
  logic [COL_W-1:0]  ref_column;

  // write-back of one byte of the walk
  logic [2:0]        lo_bit;
  logic [2:0]        hi_bit;
  mofe_pkg::byte_t   row_mask;
  logic              out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // a point is a one-pixel rectangle, so off-screen points fall out as empty
  assign x_end_in   = (kind == mofe_pkg::KIND_POINT) ? x_first : x_last;
  assign y_end_in   = (kind == mofe_pkg::KIND_POINT) ? y_first : y_last;
  assign x_end_clip = ({1'b0, x_end_in} > COL_MAX) ? COL_MAX : {1'b0, x_end_in};
  assign y_end_clip = ({1'b0, y_end_in} > ROW_MAX) ? ROW_MAX : {1'b0, y_end_in};
  assign draw_empty = ({1'b0, x_first} > x_end_clip) || ({1'b0, y_first} > y_end_clip);
  assign draw_go    = accept && !draw_empty &&
                      ((kind == mofe_pkg::KIND_POINT) || (kind == mofe_pkg::KIND_FILL));

  assign blk_in_first = y_first[3 +: PAGE_W];
  assign blk_in_last  = y_end_clip[3 +: PAGE_W];

  assign ref_is_data = (refresh_offset >= OFF_W'(mofe_pkg::HEADER_SLOTS));
  assign ref_column  = COL_W'(refresh_offset - OFF_W'(mofe_pkg::HEADER_SLOTS));

  // rows of the current byte covered by the rectangle, top row in bit 7
  assign lo_bit   = (fill_block == blk_first) ? bit_first : 3'd0;
  assign hi_bit   = (fill_block == blk_last) ? bit_last : 3'd7;
  assign row_mask = (8'hff >> lo_bit) & (8'hff << (3'd7 - hi_bit));

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {fill_column, PAGE_LAST - fill_block};
    ram_we    = 1'b0;
    ram_waddr = {fill_column, PAGE_LAST - fill_block};
    ram_wdata = pix_val ? (ram_rdata | row_mask) : (ram_rdata & ~row_mask);
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        if (draw_go) begin
          ram_re    = 1'b1;
          ram_raddr = {x_first[COL_W-1:0], PAGE_LAST - blk_in_first};
        end else if (accept && (kind == mofe_pkg::KIND_REFRESH) && ref_is_data) begin
          ram_re    = 1'b1;
          ram_raddr = {ref_column, refresh_page};
        end
      end
      ST_RMW_RD: begin
        ram_re = 1'b1;
      end
      ST_RMW_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mofe_ram #(
    .WIDTH(mofe_pkg::BYTE_W),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      refresh_page   <= '0;
      refresh_offset <= '0;
      fill_column    <= '0;
      fill_block     <= '0;
      out_valid      <= 1'b0;
    end else begin
      // the output register empties unless a refresh byte moves in this cycle
      if (out_valid && out_ready && (state != ST_REF_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (kind)
              mofe_pkg::KIND_POINT,
              mofe_pkg::KIND_FILL: begin
                fill_column <= x_first[COL_W-1:0];
                col_last    <= x_end_clip[COL_W-1:0];
                fill_block  <= blk_in_first;
                blk_first   <= blk_in_first;
                blk_last    <= blk_in_last;
                bit_first   <= y_first[2:0];
                bit_last    <= y_end_clip[2:0];
                pix_val     <= pixel_value;
                // the first read goes out with the transaction itself
                if (!draw_empty) begin
                  state <= ST_RMW_WR;
                end
              end
              mofe_pkg::KIND_CLEAR: begin
                refresh_page   <= '0;
                refresh_offset <= '0;
                clr_addr       <= '0;
                state          <= ST_CLEAR;
              end
              default: begin
                // refresh tick: the header byte or the ram read is settled now
                case (refresh_offset)
                  OFF_W'(0): pend_cmd <= mofe_pkg::CMD_PAGE_BASE + 8'(refresh_page);
                  OFF_W'(1): pend_cmd <= mofe_pkg::CMD_COL_LOW;
                  default:   pend_cmd <= mofe_pkg::CMD_COL_HIGH;
                endcase
                pend_data <= ref_is_data;
                pend_end  <= (refresh_offset == OFF_LAST) && (refresh_page == PAGE_LAST);
                if (refresh_offset == OFF_LAST) begin
                  refresh_offset <= '0;
                  refresh_page   <= (refresh_page == PAGE_LAST) ? '0 : refresh_page + 1'b1;
                end else begin
                  refresh_offset <= refresh_offset + 1'b1;
                end
                state <= ST_REF_OUT;
              end
            endcase
          end
        end
        ST_RMW_RD: begin
          state <= ST_RMW_WR;
        end
        ST_RMW_WR: begin
          if (fill_block == blk_last) begin
            if (fill_column == col_last) begin
              state <= ST_IDLE;
            end else begin
              fill_column <= fill_column + 1'b1;
              fill_block  <= blk_first;
              state       <= ST_RMW_RD;
            end
          end else begin
            fill_block <= fill_block + 1'b1;
            state      <= ST_RMW_RD;
          end
        end
        ST_REF_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= pend_data ? ram_rdata : pend_cmd;
            is_data   <= pend_data;
            frame_end <= pend_end;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/mofe_checker.sv =====
module mofe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_data,
  input logic       frame_end
);

  // the clearing pass after reset blocks input
  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken right after reset");

  // a clear transaction starts a clearing pass
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (kind == mofe_pkg::KIND_CLEAR)) |=> !in_ready)
    else $error("input taken right after a clear");

  // frame end only ever marks a data byte
  a_frame_end_is_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> is_data)
    else $error("frame end on a command byte");

  // command bytes are the page address or the column address pair
  a_command_codes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_data) |->
      ((out_byte[7:4] == mofe_pkg::CMD_PAGE_BASE[7:4]) ||
       (out_byte == mofe_pkg::CMD_COL_LOW) || (out_byte == mofe_pkg::CMD_COL_HIGH)))
    else $error("unknown command byte");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(is_data)))
    else $error("output changed while stalled");

endmodule

bind mono_oled_framebuffer_engine mofe_checker u_mofe_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .kind     (kind),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_byte (out_byte),
  .is_data  (is_data),
  .frame_end(frame_end)
);

// ===== tb/mono_oled_framebuffer_engine_test.sv =====
module mono_oled_framebuffer_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  // screen geometry at the default parameters of the block
  localparam int unsigned SCREEN_COLS  = 128;
  localparam int unsigned SCREEN_PAGES = 8;
  localparam int unsigned SCREEN_ROWS  = SCREEN_PAGES * 8;
  localparam int unsigned PAGE_SLOTS   = SCREEN_COLS + mofe_pkg::HEADER_SLOTS;

  // random part of the run, and its calm tail with no idling on either side
  localparam int unsigned RANDOM_ITEMS = 1780;
  localparam int unsigned CALM_ITEMS   = 200;
  // long enough for a whole-screen fill, a read and a write-back per byte, or for the clearing pass
  localparam int unsigned SETTLE_CYCLES = 2 * SCREEN_COLS * SCREEN_PAGES + 200;
  localparam int unsigned PRINT_CAP     = 100;

  // one input transaction, with the byte it must yield where that is typed in
  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      x_first;
    logic [7:0]      y_first;
    logic [7:0]      x_last;
    logic [7:0]      y_last;
    logic            pixel_value;
    logic            typed;
    mofe_pkg::byte_t want_byte;
    logic            want_data;
    logic            want_end;
  } stim_row_t;

  // one byte of the panel refresh stream
  typedef struct packed {
    mofe_pkg::byte_t value;
    logic            data_flag;
    logic            end_flag;
  } panel_byte_t;

  logic       clk;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [1:0] kind        = mofe_pkg::KIND_POINT;
  logic [7:0] x_first     = '0;
  logic [7:0] y_first     = '0;
  logic [7:0] x_last      = '0;
  logic [7:0] y_last      = '0;
  logic       pixel_value = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_byte;
  logic       is_data;
  logic       frame_end;

  mono_oled_framebuffer_engine u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .x_first     (x_first),
    .y_first     (y_first),
    .x_last      (x_last),
    .y_last      (y_last),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .is_data     (is_data),
    .frame_end   (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow of the frame store and of the refresh walk
  // ---------------------------------------------------------------------------

  mofe_pkg::byte_t panel_image [SCREEN_COLS * SCREEN_PAGES];
  int unsigned     scan_page;
  int unsigned     scan_slot;
  panel_byte_t     pending_bytes [$];
  int unsigned     faults;
  bit              calm_tail;
  int unsigned     ticks_since_clear;
  bit              early_clear_done;

  task automatic log_fault(string what);
    faults++;
    if (faults <= PRINT_CAP)
      $display("mismatch at %0t: %s", $time, what);
  endtask

  // store byte index is column * pages + page; top row of a byte is bit 7
  function automatic void plot(int unsigned x, int unsigned y, logic lit);
    int unsigned     idx;
    mofe_pkg::byte_t mask;
    if (x >= SCREEN_COLS || y >= SCREEN_ROWS)
      return;
    idx  = x * SCREEN_PAGES + (SCREEN_PAGES - 1 - y / 8);
    mask = 8'h80 >> (y % 8);
    if (lit)
      panel_image[idx] = panel_image[idx] | mask;
    else
      panel_image[idx] = panel_image[idx] & ~mask;
  endfunction

  function automatic void wipe_panel();
    foreach (panel_image[i])
      panel_image[i] = '0;
    scan_page = 0;
    scan_slot = 0;
  endfunction

  // applies one transaction to the shadow; returns 1 when a byte is due
  function automatic bit advance_panel(stim_row_t s, output panel_byte_t r);
    int unsigned x_end;
    int unsigned y_end;
    r = '0;
    case (s.kind)
      mofe_pkg::KIND_POINT: plot(s.x_first, s.y_first, s.pixel_value);
      mofe_pkg::KIND_FILL: begin
        // clip the far corner; off-screen near corners just plot nothing
        x_end = (s.x_last > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : s.x_last;
        y_end = (s.y_last > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : s.y_last;
        for (int x = s.x_first; x <= int'(x_end); x++)
          for (int y = s.y_first; y <= int'(y_end); y++)
            plot(x, y, s.pixel_value);
      end
      mofe_pkg::KIND_CLEAR: wipe_panel();
      mofe_pkg::KIND_REFRESH: begin
        // three header commands, then one data byte per column
        if (scan_slot == 0)
          r.value = mofe_pkg::CMD_PAGE_BASE + mofe_pkg::byte_t'(scan_page);
        else if (scan_slot == 1)
          r.value = mofe_pkg::CMD_COL_LOW;
        else if (scan_slot == 2)
          r.value = mofe_pkg::CMD_COL_HIGH;
        else begin
          r.value     = panel_image[(scan_slot - mofe_pkg::HEADER_SLOTS) * SCREEN_PAGES +
                                    scan_page];
          r.data_flag = 1'b1;
          r.end_flag  = (scan_slot == PAGE_SLOTS - 1) && (scan_page == SCREEN_PAGES - 1);
        end
        scan_slot++;
        if (scan_slot >= PAGE_SLOTS) begin
          scan_slot = 0;
          scan_page = (scan_page + 1) % SCREEN_PAGES;
        end
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // directed transactions; typed bytes only where they are obvious
  stim_row_t directed_rows [0:23] = '{
    // header of page 0 right after reset, then an empty data byte
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 1, mofe_pkg::CMD_PAGE_BASE, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 1, mofe_pkg::CMD_COL_LOW, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 1, mofe_pkg::CMD_COL_HIGH, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 1, 8'h00, 1, 0},
    // bottom-left and top-right corners
    '{mofe_pkg::KIND_POINT, 0, 63, 0, 0, 1, 0, 0, 0, 0},
    '{mofe_pkg::KIND_POINT, 127, 0, 0, 0, 1, 0, 0, 0, 0},
    // points just off the right edge, the bottom edge, and far away
    '{mofe_pkg::KIND_POINT, 128, 0, 0, 0, 1, 0, 0, 0, 0},
    '{mofe_pkg::KIND_POINT, 0, 64, 0, 0, 1, 0, 0, 0, 0},
    '{mofe_pkg::KIND_POINT, 255, 255, 255, 255, 1, 0, 0, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 255, 255, 255, 255, 1, 0, 0, 0, 0},
    // whole screen lit, far corner clipped from 255
    '{mofe_pkg::KIND_FILL, 0, 0, 255, 255, 1, 0, 0, 0, 0},
    // empty fills: columns reversed, rows reversed, left edge off screen
    '{mofe_pkg::KIND_FILL, 10, 0, 5, 63, 0, 0, 0, 0, 0},
    '{mofe_pkg::KIND_FILL, 0, 40, 127, 30, 0, 0, 0, 0, 0},
    '{mofe_pkg::KIND_FILL, 130, 0, 255, 63, 0, 0, 0, 0, 0},
    // one-pixel rectangle darkened
    '{mofe_pkg::KIND_FILL, 3, 5, 3, 5, 0, 0, 0, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // darken page 0 while it is being sent
    '{mofe_pkg::KIND_FILL, 0, 56, 127, 63, 0, 0, 0, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{mofe_pkg::KIND_POINT, 4, 60, 0, 0, 1, 0, 0, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // clear in the middle of page 0 restarts the walk
    '{mofe_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 1, mofe_pkg::CMD_PAGE_BASE, 0, 0},
    '{mofe_pkg::KIND_REFRESH, 0, 0, 0, 0, 0, 1, mofe_pkg::CMD_COL_LOW, 0, 0}
  };

  // mostly refresh ticks so whole frames go out; clears rare enough that
  // frame ends are reached, with at most one early clear to cut a frame short
  function automatic stim_row_t random_item();
    stim_row_t   s;
    int unsigned pick;
    s             = '0;
    s.x_first     = 8'($urandom_range(0, 255));
    s.y_first     = 8'($urandom_range(0, 255));
    s.x_last      = 8'($urandom_range(0, 255));
    s.y_last      = 8'($urandom_range(0, 255));
    s.pixel_value = 1'($urandom_range(0, 1));
    pick          = $urandom_range(0, 99);
    if ((ticks_since_clear > 1100 && $urandom_range(0, 29) == 0) ||
        (!early_clear_done && ticks_since_clear > 40 && ticks_since_clear < 150 &&
         $urandom_range(0, 39) == 0)) begin
      s.kind            = mofe_pkg::KIND_CLEAR;
      early_clear_done  = 1'b1;
      ticks_since_clear = 0;
    end else if (pick < 80) begin
      s.kind = mofe_pkg::KIND_REFRESH;
      ticks_since_clear++;
    end else if (pick < 91) begin
      s.kind = mofe_pkg::KIND_POINT;
      // most points on screen
      if ($urandom_range(0, 4) != 0) begin
        s.x_first = 8'($urandom_range(0, SCREEN_COLS - 1));
        s.y_first = 8'($urandom_range(0, SCREEN_ROWS - 1));
      end
    end else begin
      s.kind = mofe_pkg::KIND_FILL;
      // small rectangles near the screen, some spilling past the edges;
      // the rest keep fully random corners (empty, clipped or whole screen)
      if ($urandom_range(0, 7) != 0) begin
        s.x_first = 8'($urandom_range(0, SCREEN_COLS - 1));
        s.y_first = 8'($urandom_range(0, SCREEN_ROWS - 1));
        s.x_last  = 8'(s.x_first + $urandom_range(0, 9));
        s.y_last  = 8'(s.y_first + $urandom_range(0, 12));
      end
    end
    return s;
  endfunction

  // drops valid for a number of cycles, optionally until every byte is back;
  // every caller asks for a nonzero wait, so valid is never lowered and raised at once
  task automatic hold_off(int unsigned cycles, bit drain);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
    while (drain && pending_bytes.size() != 0)
      @(posedge clk);
  endtask

  // presents one transaction and books its byte once it is taken
  task automatic offer(stim_row_t s);
    panel_byte_t r;
    in_valid    <= 1'b1;
    kind        <= s.kind;
    x_first     <= s.x_first;
    y_first     <= s.y_first;
    x_last      <= s.x_last;
    y_last      <= s.y_last;
    pixel_value <= s.pixel_value;
    do @(posedge clk); while (!in_ready);
    if (advance_panel(s, r)) begin
      if (s.typed)
        pending_bytes.push_back(panel_byte_t'{s.want_byte, s.want_data, s.want_end});
      else
        pending_bytes.push_back(r);
    end
  endtask

  initial begin : stimulus
    bit gappy;
    gappy = 1'b1;
    wipe_panel();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if ($urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 9), 1'b0);
      offer(directed_rows[i]);
    end
    // sender waits for the whole directed stream before going random
    hold_off(1, 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate stretches with and without sender gaps
      if (n % 64 == 0)
        gappy = ($urandom_range(0, 2) != 0);
      if (n == RANDOM_ITEMS - CALM_ITEMS)
        calm_tail = 1'b1;
      if (n == RANDOM_ITEMS / 2)
        hold_off(1, 1'b1);
      else if (!calm_tail && gappy && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 9), 1'b0);
      offer(random_item());
    end

    // drain, then allow a trailing fill or clear to finish quietly
    hold_off(1, 1'b1);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (faults == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // output side: check each byte, stall the receiver in bursts
  // ---------------------------------------------------------------------------

  panel_byte_t oldest;
  int unsigned ready_left;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0)
        log_fault($sformatf("unexpected byte %02h is_data %0b frame_end %0b",
                            out_byte, is_data, frame_end));
      else begin
        oldest = pending_bytes.pop_front();
        if (out_byte !== oldest.value)
          log_fault($sformatf("out_byte %02h, wanted %02h", out_byte, oldest.value));
        if (is_data !== oldest.data_flag)
          log_fault($sformatf("is_data %0b, wanted %0b", is_data, oldest.data_flag));
        if (frame_end !== oldest.end_flag)
          log_fault($sformatf("frame_end %0b, wanted %0b", frame_end, oldest.end_flag));
      end
    end
    // receiver: runs of ready broken by stall bursts, none in the tail
    if (ready_left != 0)
      ready_left = ready_left - 1;
    else if (calm_tail) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      ready_left = $urandom_range(1, 9) - 1;
    end else begin
      out_ready  <= 1'b1;
      ready_left = $urandom_range(1, 24) - 1;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/mofe_pkg.sv
hw/rtl/mofe_ram.sv
hw/rtl/mono_oled_framebuffer_engine.sv
hw/rtl/mofe_checker.sv
tb/mono_oled_framebuffer_engine_test.sv
